FILE: sv/ctpd_pkg.sv
package ctpd_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned WORD_W = 5;
  localparam int unsigned PEND_W = 7;
  localparam int unsigned PCNT_W = 3;
  localparam int unsigned LEN_W  = 4;

  // Default depth of the result queue in front of the output channel.
  localparam int unsigned OUT_DEPTH = 4;

  // Command codes.
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOL  = 1'b1;

  // Fixed words for the punctuation characters.
  localparam logic [WORD_W-1:0] WORD_SPACE  = 5'd26;
  localparam logic [WORD_W-1:0] WORD_PERIOD = 5'd27;
  localparam logic [WORD_W-1:0] WORD_COMMA  = 5'd28;
  localparam logic [WORD_W-1:0] WORD_DASH   = 5'd29;
  localparam logic [WORD_W-1:0] WORD_QUOTE  = 5'd30;
  localparam logic [WORD_W-1:0] WORD_QMARK  = 5'd31;

  localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] ASCII_PERIOD  = 8'h2E;
  localparam logic [CHAR_W-1:0] ASCII_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] ASCII_DASH    = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_QUOTE   = 8'h27;
  localparam logic [CHAR_W-1:0] ASCII_QMARK   = 8'h3F;
  localparam logic [CHAR_W-1:0] ASCII_A       = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_NEWLINE = 8'h0A;

  typedef struct packed {
    logic [CHAR_W-1:0] decoded_char;
    logic              is_newline;
    logic              last;
  } res_t;

  typedef struct packed {
    logic              hit;
    logic [CHAR_W-1:0] ch;
  } match_t;

  // Everything the decoder hands back for one item.
  typedef struct packed {
    logic [1:0]        n;
    res_t [1:0]        res;
    logic [PEND_W-1:0] next_bits;
    logic [PCNT_W-1:0] next_cnt;
  } dec_t;

  function automatic logic [WORD_W-1:0] char_to_word(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    logic [WORD_W-1:0] w;
    d = c - ASCII_A;
    unique case (c)
      ASCII_SPACE:  w = WORD_SPACE;
      ASCII_PERIOD: w = WORD_PERIOD;
      ASCII_COMMA:  w = WORD_COMMA;
      ASCII_DASH:   w = WORD_DASH;
      ASCII_QUOTE:  w = WORD_QUOTE;
      ASCII_QMARK:  w = WORD_QMARK;
      default:      w = d[WORD_W-1:0];
    endcase
    return w;
  endfunction

  // Prefix code table, keyed by codeword length and value.
  function automatic match_t lookup_code(input logic [LEN_W-1:0] len,
                                         input logic [CHAR_W-1:0] bits);
    match_t m;
    m.hit = 1'b1;
    unique case ({len, bits})
      {4'd3, 8'h05}: m.ch = " ";
      {4'd6, 8'h00}: m.ch = "'";
      {4'd6, 8'h03}: m.ch = ",";
      {4'd8, 8'h91}: m.ch = "-";
      {4'd6, 8'h11}: m.ch = ".";
      {4'd6, 8'h01}: m.ch = "?";
      {4'd6, 8'h25}: m.ch = "A";
      {4'd8, 8'h9A}: m.ch = "B";
      {4'd4, 8'h05}: m.ch = "C";
      {4'd4, 8'h01}: m.ch = "D";
      {4'd3, 8'h06}: m.ch = "E";
      {4'd5, 8'h09}: m.ch = "F";
      {4'd8, 8'h9B}: m.ch = "G";
      {4'd6, 8'h10}: m.ch = "H";
      {4'd4, 8'h07}: m.ch = "I";
      {4'd8, 8'h98}: m.ch = "J";
      {4'd4, 8'h06}: m.ch = "K";
      {4'd5, 8'h04}: m.ch = "L";
      {4'd8, 8'h99}: m.ch = "M";
      {4'd8, 8'h9E}: m.ch = "N";
      {4'd5, 8'h05}: m.ch = "O";
      {4'd3, 8'h07}: m.ch = "P";
      {4'd8, 8'h9F}: m.ch = "Q";
      {4'd4, 8'h08}: m.ch = "R";
      {4'd5, 8'h06}: m.ch = "S";
      {4'd5, 8'h07}: m.ch = "T";
      {4'd8, 8'h9C}: m.ch = "U";
      {4'd8, 8'h9D}: m.ch = "V";
      {4'd6, 8'h02}: m.ch = "W";
      {4'd8, 8'h92}: m.ch = "X";
      {4'd8, 8'h93}: m.ch = "Y";
      {4'd8, 8'h90}: m.ch = "Z";
      default: begin
        m.hit = 1'b0;
        m.ch  = '0;
      end
    endcase
    return m;
  endfunction

endpackage

FILE: sv/ctpd_if.sv
interface ctpd_in_if;
  import ctpd_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output command, output char_code, input ready);
  modport sink (input valid, input command, input char_code, output ready);
endinterface

interface ctpd_out_if;
  import ctpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] decoded_char;
  logic              is_newline;
  logic              last;

  modport source (output valid, output decoded_char, output is_newline, output last,
                  input ready);
  modport sink (input valid, input decoded_char, input is_newline, input last,
                output ready);
endinterface

FILE: sv/ctpd_decode.sv
module ctpd_decode (
  input  logic                      command_i,
  input  logic [ctpd_pkg::CHAR_W-1:0] char_code_i,
  input  logic [ctpd_pkg::PEND_W-1:0] pend_bits_i,
  input  logic [ctpd_pkg::PCNT_W-1:0] pend_cnt_i,
  output ctpd_pkg::dec_t            dec_o
);
  import ctpd_pkg::*;

  // Five bit steps, each one shift, one table match and a possible flush.
  always_comb begin
    logic [CHAR_W-1:0] sreg;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] word;
    logic [1:0]        n;
    match_t            m;
    res_t [1:0]        res;

    sreg = {1'b0, pend_bits_i};
    len  = {1'b0, pend_cnt_i};
    word = char_to_word(char_code_i);
    n    = 2'd0;
    res  = '0;

    for (int b = WORD_W - 1; b >= 0; b--) begin
      sreg = {sreg[CHAR_W-2:0], word[b]};
      len  = len + 4'd1;
      m    = lookup_code(len, sreg);
      if (m.hit) begin
        if (n == 2'd0) begin
          res[0].decoded_char = m.ch;
          n = 2'd1;
        end else if (n == 2'd1) begin
          res[1].decoded_char = m.ch;
          n = 2'd2;
        end
        sreg = '0;
        len  = '0;
      end else if (len >= 4'd8) begin
        sreg = '0;
        len  = '0;
      end
    end

    if (n == 2'd1) begin
      res[0].last = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last = 1'b1;
    end

    if (command_i == CMD_EOL) begin
      dec_o.n         = 2'd1;
      dec_o.res       = '0;
      dec_o.res[0]    = '{decoded_char: ASCII_NEWLINE, is_newline: 1'b1, last: 1'b1};
      dec_o.next_bits = '0;
      dec_o.next_cnt  = '0;
    end else begin
      dec_o.n         = n;
      dec_o.res       = res;
      dec_o.next_bits = sreg[PEND_W-1:0];
      dec_o.next_cnt  = len[PCNT_W-1:0];
    end
  end

endmodule

FILE: sv/char_to_prefix_code_decoder.sv
// Prefix-code text decoder. Each input word is either a character (command 0) or an
// end-of-line command (command 1). A character is turned into a 5-bit code, most
// significant bit first, and those bits are matched one by one against a fixed
// prefix-free table of 32 codewords from 3 to 8 bits long; each match yields one
// output word with the decoded character, and up to seven unmatched bits carry over
// to the next character. A character therefore yields zero, one or two output words,
// and the last of them has last set. End of line yields exactly one word (newline,
// is_newline and last set) and drops the carried bits. Timing: the input channel can
// take one word every cycle while the decoder is not stalled by a full result queue.
// An accepted word is held in the input register, is decoded from there into a small
// result queue once the queue has room for two results, and its results leave from
// the head of the queue. The output channel delivers one result per cycle while
// ready is high, so the sustained rate is one input word per cycle as long as each
// yields at most one result; the queue (OutDepth entries) absorbs any second result.
module char_to_prefix_code_decoder #(
  parameter int unsigned OutDepth = ctpd_pkg::OUT_DEPTH
) (
  input logic       clk_i,
  input logic       rst_ni,
  ctpd_in_if.sink   in_i,
  ctpd_out_if.source out_o
);
  import ctpd_pkg::*;

  localparam int unsigned CntW = $clog2(OutDepth + 1);

  // Input register.
  logic              in_vld_q;
  logic              in_cmd_q;
  logic [CHAR_W-1:0] in_char_q;

  // Bits left over from earlier characters.
  logic [PEND_W-1:0] pend_bits_q, pend_bits_d;
  logic [PCNT_W-1:0] pend_cnt_q, pend_cnt_d;

  // Result queue; entry 0 always drives the output.
  res_t              queue_q [OutDepth];
  res_t              queue_d [OutDepth];
  logic [CntW-1:0]   count_q, count_d;

  dec_t              dec;
  logic              fire;
  logic              pop;
  logic [CntW-1:0]   push_n;
  logic [CntW-1:0]   base;

  // The registered word is decoded once the queue has room for two results, which
  // is the most a single word can produce.
  assign fire       = in_vld_q && (count_q <= CntW'(OutDepth - 2));
  assign in_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_cmd_q  <= in_i.command;
      in_char_q <= in_i.char_code;
    end
  end

  ctpd_decode u_decode (
    .command_i   (in_cmd_q),
    .char_code_i (in_char_q),
    .pend_bits_i (pend_bits_q),
    .pend_cnt_i  (pend_cnt_q),
    .dec_o       (dec)
  );

  // Carried bits advance only when a word is actually decoded.
  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    if (fire) begin
      pend_bits_d = dec.next_bits;
      pend_cnt_d  = dec.next_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

  // Queue update: a pop shifts everything down by one, and new results land right
  // behind whatever remains after the pop.
  assign pop    = out_o.valid && out_o.ready;
  assign push_n = fire ? CntW'(dec.n) : '0;
  assign base   = count_q - CntW'(pop);

  always_comb begin
    for (int i = 0; i < OutDepth; i++) begin
      queue_d[i] = queue_q[i];
    end
    if (pop) begin
      for (int i = 0; i < OutDepth - 1; i++) begin
        queue_d[i] = queue_q[i + 1];
      end
    end
    for (int i = 0; i < OutDepth; i++) begin
      if ((push_n != '0) && (CntW'(i) == base)) begin
        queue_d[i] = dec.res[0];
      end
      if ((push_n == CntW'(2)) && (CntW'(i) == base + CntW'(1))) begin
        queue_d[i] = dec.res[1];
      end
    end
    count_d = base + push_n;
  end

  always_ff @(posedge clk_i) begin
    queue_q <= queue_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign out_o.valid        = (count_q != '0);
  assign out_o.decoded_char = queue_q[0].decoded_char;
  assign out_o.is_newline   = queue_q[0].is_newline;
  assign out_o.last         = queue_q[0].last;

  // The queue never holds more results than it has entries.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(OutDepth))
    else $error("result queue overflow");

  // End of line leaves no carried bits behind.
  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_cmd_q == CMD_EOL)) |=> (pend_cnt_q == '0) && (pend_bits_q == '0))
    else $error("carried bits survive end of line");

  // A decoded word that produces results makes the output valid next cycle.
  a_result_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (dec.n != 2'd0)) |=> out_o.valid)
    else $error("decoded result not presented");

  // Bits above the carried count are always zero, so an empty carry holds no bits.
  a_carry_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> (dec.next_cnt != '0) || (dec.next_bits == '0))
    else $error("nonzero carried bits with zero count");

endmodule
